// File: rtl/core/vds_pkg.sv
// shared types, constants and fixed-point helpers for the vehicle dynamics step
package vds_pkg;

  localparam int CORD_W = 44;          // cordic x/y datapath width
  localparam int ANG_W  = 21;          // cordic angle accumulator width
  localparam int HEAD_W = 19;          // wrapped heading width
  localparam int CNT_W  = 5;           // step counter, indexes the 32-entry atan table
  localparam int MOD_STEPS = 14;       // restoring steps of the heading wrap
  localparam int ARM_W  = 50;          // lever arm product width

  localparam int PI_Q        = 205887;
  localparam int HALF_PI_Q   = 102944;
  localparam int TWO_PI_Q    = 411774;
  localparam int CORDIC_GAIN = 39797;
  localparam int TRAC_SCALE  = 6553600;  // 100.0 in q16.16

  localparam logic signed [31:0] POS_X_RST = -32'sd2621440;
  localparam logic signed [31:0] POS_Y_RST = 32'sd1310720;

  localparam logic [3:0] CFG_CORNER_F  = 4'd0;
  localparam logic [3:0] CFG_CORNER_R  = 4'd1;
  localparam logic [3:0] CFG_MAX_GRIP  = 4'd2;
  localparam logic [3:0] CFG_AXLE_LOAD = 4'd3;
  localparam logic [3:0] CFG_INV_MASS  = 4'd4;
  localparam logic [3:0] CFG_INV_INER  = 4'd5;
  localparam logic [3:0] CFG_ROLLING   = 4'd6;
  localparam logic [3:0] CFG_DRAG      = 4'd7;

  typedef enum logic [5:0] {
    S_IDLE, S_HFOLD, S_HCORD, S_HDONE, S_SFOLD, S_SCORD, S_SDONE,
    S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_YCORD, S_BCORD, S_SLIP,
    S_LF1, S_LF2, S_LF3, S_LF4, S_TR,
    S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_R7, S_R8,
    S_L1, S_M1, S_M2, S_A1, S_A2, S_A3, S_W1, S_W2, S_W3, S_W4,
    S_V1, S_V2, S_P1, S_P2, S_Y1, S_Y2, S_H1, S_HMOD, S_HOUT
  } vds_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    if (v > 68'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // q16.16 product scaling with saturation
  function automatic logic signed [31:0] q16(input logic signed [65:0] p);
    return sat32(68'(p) >>> 16);
  endfunction

  function automatic logic [16:0] atan_lut(input logic [CNT_W-1:0] i);
    logic [16:0] r;
    case (i)
      5'd0:    r = 17'd51472;
      5'd1:    r = 17'd30385;
      5'd2:    r = 17'd16055;
      5'd3:    r = 17'd8150;
      5'd4:    r = 17'd4091;
      5'd5:    r = 17'd2047;
      5'd6:    r = 17'd1024;
      5'd7:    r = 17'd512;
      5'd8:    r = 17'd256;
      5'd9:    r = 17'd128;
      5'd10:   r = 17'd64;
      5'd11:   r = 17'd32;
      5'd12:   r = 17'd16;
      5'd13:   r = 17'd8;
      5'd14:   r = 17'd4;
      5'd15:   r = 17'd2;
      5'd16:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/vehicle_dynamics_step.sv
// two-axle car body, one euler step per transaction, on a shared multiplier and cordic
//
// usage
//   config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; always ready,
//   register i of the list is written at index i, unknown indexes are dropped. write only
//   while the block is idle.
//   input channel: in_valid_i/in_ready_o carries one step (steer, throttle, brake, time
//   step, half-grip flags). in_ready_o is high only while the sequencer is idle.
//   output channel: out_valid_o/out_ready_i carries the new position, world velocity,
//   heading, yaw rate and the car-frame velocity seen at the start of the step.
// sequence
//   a transaction runs from accept back to idle; when forward speed is zero, the two
//   atan passes are skipped. its length is set by the single cordic step unit (four
//   passes: heading sin/cos, steer sin/cos, two atan), the single 33x33 multiplier used
//   for thirty-two products, and the 14-step restoring reduction of the heading wrap.
// reset
//   position goes to (-40, 20), velocities, heading and yaw rate to zero, config
//   registers to their defaults, no result pending.
// stall
//   the result sits in an output register; the next transaction is taken meanwhile.
//   if a new result is ready while the old one is still not taken, the sequencer
//   holds in its last state until the output register frees up.
module vehicle_dynamics_step #(
  parameter int WHEELBASE_Q8 = 512,
  parameter int FRONT_ARM_Q8 = 256,
  parameter int REAR_ARM_Q8  = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // step input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [16:0] steer_angle_i,
  input  logic [6:0]         throttle_level_i,
  input  logic [6:0]         brake_level_i,
  input  logic [15:0]        time_step_i,
  input  logic               front_half_grip_i,
  input  logic               rear_half_grip_i,
  // step result
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] world_vel_x_o,
  output logic signed [31:0] world_vel_y_o,
  output logic signed [18:0] heading_o,
  output logic signed [31:0] yaw_rate_o,
  output logic signed [31:0] body_vel_forward_o,
  output logic signed [31:0] body_vel_lateral_o
);
  import vds_pkg::*;

  // sequencer
  vds_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic cnt_last;
  logic out_free;

  // config registers
  logic signed [31:0] cf_q, cr_q;
  logic [30:0] grip_q, axle_q, roll_q, drag_q;
  logic [31:0] imass_q, iiner_q;

  // body state
  logic signed [31:0] posx_q, posx_d, posy_q, posy_d;
  logic signed [31:0] vwx_q, vwx_d, vwy_q, vwy_d, rate_q, rate_d;
  logic signed [HEAD_W-1:0] head_q, head_d;

  // latched step input
  logic signed [16:0] steer_q;
  logic [6:0] thr_q, brk_q;
  logic [15:0] dt_q;
  logic hf_q, hr_q;

  // shared multiplier, operands chosen per state, product registered
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [31:0] pq;       // product in q16.16, saturated
  logic signed [31:0] pq32;     // product scaled by 2^-32, saturated

  // shared cordic step unit
  logic signed [CORD_W-1:0] cx_q, cx_d, cy_q, cy_d, cx_n, cy_n, xs, ys;
  logic signed [ANG_W-1:0] cz_q, cz_d, cz_n, tab;
  logic rot_q, rot_d, neg_q, neg_d, up;

  // angle fold into +-pi/2
  logic signed [ANG_W-1:0] fold_src, fold_z;
  logic fold_neg;

  // intermediates
  logic signed [31:0] sh_q, sh_d, ch_q, ch_d, cst_q, cst_d;
  logic signed [31:0] fwd_q, fwd_d, lat_q, lat_d, t0_q, t0_d, t1_q, t1_d;
  logic signed [39:0] yawv_q, yawv_d;
  logic signed [ANG_W-1:0] yaw_q, yaw_d, beta_q, beta_d;
  logic signed [31:0] latf_q, latf_d, latr_q, latr_d, trac_q, trac_d;
  logic signed [31:0] ffwd_q, ffwd_d, flat_q, flat_d, mom_q, mom_d;
  logic signed [31:0] afwd_q, afwd_d, alat_q, alat_d, aang_q, aang_d;
  logic signed [31:0] awx_q, awx_d, awy_q, awy_d;
  logic signed [ARM_W-1:0] wide_q, wide_d;
  logic [33:0] mod_q, mod_d, mod_cmp;
  logic signed [34:0] head_sum;

  logic signed [32:0] fwd_abs, lat_abs;
  logic signed [22:0] slip_f, slip_r;
  logic signed [8:0] trac_diff;

  // result register
  logic out_valid_q, out_valid_d;
  logic signed [31:0] o_posx_q, o_posy_q, o_vwx_q, o_vwy_q, o_rate_q, o_fwd_q, o_lat_q;
  logic signed [HEAD_W-1:0] o_head_q;

  function automatic logic signed [31:0] clamp_grip(input logic signed [31:0] v,
                                                    input logic [30:0] g);
    logic signed [32:0] gs;
    gs = signed'({2'b00, g});
    if (33'(v) > gs) begin
      return 32'(gs);
    end else if (33'(v) < -gs) begin
      return 32'(-gs);
    end
    return v;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign cnt_last    = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

  assign pq   = q16(prod_q);
  assign pq32 = sat32(68'(prod_q) >>> 32);

  // cordic micro-rotation; rotation mode steers z to zero, vectoring mode steers y to zero
  assign xs  = cx_q >>> cnt_q;
  assign ys  = cy_q >>> cnt_q;
  assign tab = signed'(ANG_W'(atan_lut(cnt_q)));
  assign up  = rot_q ? !cz_q[ANG_W-1] : cy_q[CORD_W-1];
  assign cx_n = up ? cx_q - ys : cx_q + ys;
  assign cy_n = up ? cy_q + xs : cy_q - xs;
  assign cz_n = up ? cz_q - tab : cz_q + tab;

  assign fold_src = (state_q == S_HFOLD) ? ANG_W'(head_q) : ANG_W'(steer_q);
  always_comb begin
    fold_z   = fold_src;
    fold_neg = 1'b0;
    if (fold_src > ANG_W'(HALF_PI_Q)) begin
      fold_z   = fold_src - ANG_W'(PI_Q);
      fold_neg = 1'b1;
    end else if (fold_src < -ANG_W'(HALF_PI_Q)) begin
      fold_z   = fold_src + ANG_W'(PI_Q);
      fold_neg = 1'b1;
    end
  end

  assign fwd_abs = fwd_q[31] ? -33'(fwd_q) : 33'(fwd_q);
  assign lat_abs = lat_q[31] ? -33'(lat_q) : 33'(lat_q);
  assign slip_f  = 23'(beta_q) + 23'(yaw_q) - 23'(steer_q);
  assign slip_r  = 23'(beta_q) - 23'(yaw_q);

  // throttle minus brake in the direction of travel; brake does nothing at standstill
  always_comb begin
    if (fwd_q > 32'sd0) begin
      trac_diff = signed'({2'b00, thr_q}) - signed'({2'b00, brk_q});
    end else if (fwd_q < 32'sd0) begin
      trac_diff = signed'({2'b00, thr_q}) + signed'({2'b00, brk_q});
    end else begin
      trac_diff = signed'({2'b00, thr_q});
    end
  end

  assign head_sum = 35'(head_q) + 35'(prod_q >>> 16) + 35'(PI_Q);
  assign mod_cmp  = 34'(TWO_PI_Q) << cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_HFOLD;
      S_HFOLD: state_d = S_HCORD;
      S_HCORD: if (cnt_last) state_d = S_HDONE;
      S_HDONE: state_d = S_SFOLD;
      S_SFOLD: state_d = S_SCORD;
      S_SCORD: if (cnt_last) state_d = S_SDONE;
      S_SDONE: state_d = S_F1;
      S_F1:    state_d = S_F2;
      S_F2:    state_d = S_F3;
      S_F3:    state_d = S_F4;
      S_F4:    state_d = S_F5;
      S_F5:    state_d = S_F6;
      S_F6:    state_d = (fwd_q == 32'sd0) ? S_SLIP : S_YCORD;
      S_YCORD: if (cnt_last) state_d = S_BCORD;
      S_BCORD: if (cnt_last) state_d = S_SLIP;
      S_SLIP:  state_d = S_LF1;
      S_LF1:   state_d = S_LF2;
      S_LF2:   state_d = S_LF3;
      S_LF3:   state_d = S_LF4;
      S_LF4:   state_d = S_TR;
      S_TR:    state_d = S_R1;
      S_R1:    state_d = S_R2;
      S_R2:    state_d = S_R3;
      S_R3:    state_d = S_R4;
      S_R4:    state_d = S_R5;
      S_R5:    state_d = S_R6;
      S_R6:    state_d = S_R7;
      S_R7:    state_d = S_R8;
      S_R8:    state_d = S_L1;
      S_L1:    state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_A1;
      S_A1:    state_d = S_A2;
      S_A2:    state_d = S_A3;
      S_A3:    state_d = S_W1;
      S_W1:    state_d = S_W2;
      S_W2:    state_d = S_W3;
      S_W3:    state_d = S_W4;
      S_W4:    state_d = S_V1;
      S_V1:    state_d = S_V2;
      S_V2:    state_d = S_P1;
      S_P1:    state_d = S_P2;
      S_P2:    state_d = S_Y1;
      S_Y1:    state_d = S_Y2;
      S_Y2:    state_d = S_H1;
      S_H1:    state_d = S_HMOD;
      S_HMOD:  if (cnt_q == '0) state_d = S_HOUT;
      S_HOUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    cnt_d = cnt_q;
    mul_a = '0;
    mul_b = '0;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; rot_d = rot_q; neg_d = neg_q;
    posx_d = posx_q; posy_d = posy_q; vwx_d = vwx_q; vwy_d = vwy_q;
    rate_d = rate_q; head_d = head_q;
    sh_d = sh_q; ch_d = ch_q; cst_d = cst_q;
    fwd_d = fwd_q; lat_d = lat_q; t0_d = t0_q; t1_d = t1_q;
    yawv_d = yawv_q; yaw_d = yaw_q; beta_d = beta_q;
    latf_d = latf_q; latr_d = latr_q; trac_d = trac_q;
    ffwd_d = ffwd_q; flat_d = flat_q; mom_d = mom_q;
    afwd_d = afwd_q; alat_d = alat_q; aang_d = aang_q;
    awx_d = awx_q; awy_d = awy_q; wide_d = wide_q; mod_d = mod_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: ;
      S_HFOLD, S_SFOLD: begin
        cx_d  = CORD_W'(CORDIC_GAIN);
        cy_d  = '0;
        cz_d  = fold_z;
        neg_d = fold_neg;
        rot_d = 1'b1;
        cnt_d = '0;
      end
      S_HCORD, S_SCORD: begin
        cx_d = cx_n; cy_d = cy_n; cz_d = cz_n;
        cnt_d = cnt_q + 1'b1;
      end
      S_HDONE: begin
        sh_d = neg_q ? 32'(-cy_q) : 32'(cy_q);
        ch_d = neg_q ? 32'(-cx_q) : 32'(cx_q);
      end
      S_SDONE: cst_d = neg_q ? 32'(-cx_q) : 32'(cx_q);
      // rotate world velocity into the car frame
      S_F1: begin mul_a = 33'(ch_q); mul_b = 33'(vwy_q); end
      S_F2: begin t0_d = pq; mul_a = 33'(sh_q); mul_b = 33'(vwx_q); end
      S_F3: begin
        fwd_d = sat32(68'(t0_q) + 68'(pq));
        mul_a = 33'(ch_q); mul_b = 33'(vwx_q);
      end
      S_F4: begin t0_d = pq; mul_a = 33'(sh_q); mul_b = 33'(vwy_q); end
      S_F5: begin
        lat_d = sat32(68'(t0_q) - 68'(pq));
        mul_a = 33'(WHEELBASE_Q8); mul_b = 33'(rate_q);
      end
      S_F6: begin
        yawv_d = 40'(prod_q >>> 9);
        yaw_d  = '0;
        beta_d = '0;
        cx_d   = CORD_W'(fwd_abs);
        cy_d   = fwd_q[31] ? -CORD_W'(40'(prod_q >>> 9)) : CORD_W'(40'(prod_q >>> 9));
        cz_d   = '0;
        rot_d  = 1'b0;
        cnt_d  = '0;
      end
      S_YCORD: begin
        cx_d = cx_n; cy_d = cy_n; cz_d = cz_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          yaw_d = cz_n;
          cx_d  = CORD_W'(fwd_abs);
          cy_d  = fwd_q[31] ? -CORD_W'(lat_q) : CORD_W'(lat_q);
          cz_d  = '0;
          cnt_d = '0;
        end
      end
      S_BCORD: begin
        cx_d = cx_n; cy_d = cy_n; cz_d = cz_n;
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) beta_d = cz_n;
      end
      // cornering forces
      S_SLIP: begin mul_a = 33'(cf_q); mul_b = 33'(slip_f); end
      S_LF1: begin
        t0_d = clamp_grip(pq, grip_q);
        mul_a = 33'(cr_q); mul_b = 33'(slip_r);
      end
      S_LF2: begin
        t1_d = clamp_grip(pq, grip_q);
        mul_a = 33'(t0_q); mul_b = signed'({2'b00, axle_q});
      end
      S_LF3: begin
        latf_d = hf_q ? (pq >>> 1) : pq;
        mul_a = 33'(t1_q); mul_b = signed'({2'b00, axle_q});
      end
      S_LF4: begin
        latr_d = hr_q ? (pq >>> 1) : pq;
        mul_a = 33'(trac_diff); mul_b = 33'(TRAC_SCALE);
      end
      S_TR: begin
        trac_d = hr_q ? (32'(prod_q) >>> 1) : 32'(prod_q);
        mul_a = signed'({2'b00, roll_q}); mul_b = 33'(fwd_q);
      end
      // rolling resistance and drag, forward then lateral
      S_R1: begin t0_d = pq; mul_a = signed'({2'b00, drag_q}); mul_b = 33'(fwd_q); end
      S_R2: t1_d = pq;
      S_R3: begin mul_a = 33'(t1_q); mul_b = fwd_abs; end
      S_R4: begin
        ffwd_d = sat32(68'(trac_q) + 68'(sat32(-(68'(t0_q) + 68'(pq)))));
        mul_a = signed'({2'b00, roll_q}); mul_b = 33'(lat_q);
      end
      S_R5: begin t0_d = pq; mul_a = signed'({2'b00, drag_q}); mul_b = 33'(lat_q); end
      S_R6: t1_d = pq;
      S_R7: begin mul_a = 33'(t1_q); mul_b = lat_abs; end
      S_R8: begin
        t0_d = sat32(-(68'(t0_q) + 68'(pq)));
        mul_a = 33'(cst_q); mul_b = 33'(latf_q);
      end
      S_L1: begin
        flat_d = sat32(68'(pq) + 68'(latr_q) + 68'(t0_q));
        mul_a = 33'(FRONT_ARM_Q8); mul_b = 33'(latf_q);
      end
      S_M1: begin
        wide_d = ARM_W'(prod_q);
        mul_a = 33'(REAR_ARM_Q8); mul_b = 33'(latr_q);
      end
      S_M2: begin
        mom_d = sat32((68'(wide_q) - 68'(prod_q)) >>> 8);
        mul_a = 33'(ffwd_q); mul_b = signed'({1'b0, imass_q});
      end
      // accelerations
      S_A1: begin
        afwd_d = pq32;
        mul_a = 33'(flat_q); mul_b = signed'({1'b0, imass_q});
      end
      S_A2: begin
        alat_d = pq32;
        mul_a = 33'(mom_q); mul_b = signed'({1'b0, iiner_q});
      end
      S_A3: begin
        aang_d = pq32;
        mul_a = 33'(ch_q); mul_b = 33'(alat_d);
      end
      // back to world frame
      S_W1: begin t0_d = pq; mul_a = 33'(sh_q); mul_b = 33'(afwd_q); end
      S_W2: begin
        awx_d = sat32(68'(t0_q) + 68'(pq));
        mul_a = 33'(ch_q); mul_b = 33'(afwd_q);
      end
      S_W3: begin t0_d = pq; mul_a = 33'(sh_q); mul_b = 33'(alat_q); end
      S_W4: begin
        awy_d = sat32(68'(t0_q) - 68'(pq));
        mul_a = signed'({17'd0, dt_q}); mul_b = 33'(awx_d);
      end
      // euler integration, velocity before position
      S_V1: begin
        vwx_d = sat32(68'(vwx_q) + (68'(prod_q) >>> 16));
        mul_a = signed'({17'd0, dt_q}); mul_b = 33'(awy_q);
      end
      S_V2: begin
        vwy_d = sat32(68'(vwy_q) + (68'(prod_q) >>> 16));
        mul_a = signed'({17'd0, dt_q}); mul_b = 33'(vwx_q);
      end
      S_P1: begin
        posx_d = sat32(68'(posx_q) + (68'(prod_q) >>> 16));
        mul_a = signed'({17'd0, dt_q}); mul_b = 33'(vwy_q);
      end
      S_P2: begin
        posy_d = sat32(68'(posy_q) + (68'(prod_q) >>> 16));
        mul_a = signed'({17'd0, dt_q}); mul_b = 33'(aang_q);
      end
      S_Y1: rate_d = sat32(68'(rate_q) + (68'(prod_q) >>> 16));
      S_Y2: begin mul_a = signed'({17'd0, dt_q}); mul_b = 33'(rate_q); end
      // heading wrap: shift into a non-negative range, then restoring reduction by 2*pi
      S_H1: begin
        if (head_sum < 35'sd0) begin
          mod_d = 34'(head_sum + (35'(TWO_PI_Q) <<< (MOD_STEPS - 1)));
        end else begin
          mod_d = 34'(head_sum);
        end
        cnt_d = CNT_W'(MOD_STEPS - 1);
      end
      S_HMOD: begin
        if (mod_q >= mod_cmp) mod_d = mod_q - mod_cmp;
        if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
      end
      S_HOUT: begin
        if (out_free) begin
          head_d = HEAD_W'(signed'({1'b0, mod_q}) - 35'(PI_Q));
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control, body state and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      posx_q      <= POS_X_RST;
      posy_q      <= POS_Y_RST;
      vwx_q       <= '0;
      vwy_q       <= '0;
      rate_q      <= '0;
      head_q      <= '0;
      cf_q        <= -32'sd327680;
      cr_q        <= -32'sd340787;
      grip_q      <= 31'd131072;
      axle_q      <= 31'd481689600;
      imass_q     <= 32'd2863311;
      iiner_q     <= 32'd2863311;
      roll_q      <= 31'd1966080;
      drag_q      <= 31'd327680;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      posx_q      <= posx_d;
      posy_q      <= posy_d;
      vwx_q       <= vwx_d;
      vwy_q       <= vwy_d;
      rate_q      <= rate_d;
      head_q      <= head_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_CORNER_F:  cf_q    <= signed'(cfg_data_i);
          CFG_CORNER_R:  cr_q    <= signed'(cfg_data_i);
          CFG_MAX_GRIP:  grip_q  <= cfg_data_i[30:0];
          CFG_AXLE_LOAD: axle_q  <= cfg_data_i[30:0];
          CFG_INV_MASS:  imass_q <= cfg_data_i;
          CFG_INV_INER:  iiner_q <= cfg_data_i;
          CFG_ROLLING:   roll_q  <= cfg_data_i[30:0];
          CFG_DRAG:      drag_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; rot_q <= rot_d; neg_q <= neg_d;
    sh_q <= sh_d; ch_q <= ch_d; cst_q <= cst_d;
    fwd_q <= fwd_d; lat_q <= lat_d; t0_q <= t0_d; t1_q <= t1_d;
    yawv_q <= yawv_d; yaw_q <= yaw_d; beta_q <= beta_d;
    latf_q <= latf_d; latr_q <= latr_d; trac_q <= trac_d;
    ffwd_q <= ffwd_d; flat_q <= flat_d; mom_q <= mom_d;
    afwd_q <= afwd_d; alat_q <= alat_d; aang_q <= aang_d;
    awx_q <= awx_d; awy_q <= awy_d; wide_q <= wide_d; mod_q <= mod_d;
    if (in_valid_i && in_ready_o) begin
      steer_q <= steer_angle_i;
      thr_q   <= throttle_level_i;
      brk_q   <= brake_level_i;
      dt_q    <= time_step_i;
      hf_q    <= front_half_grip_i;
      hr_q    <= rear_half_grip_i;
    end
    if (state_q == S_HOUT && out_free) begin
      o_posx_q <= posx_q;
      o_posy_q <= posy_q;
      o_vwx_q  <= vwx_q;
      o_vwy_q  <= vwy_q;
      o_rate_q <= rate_q;
      o_head_q <= head_d;
      o_fwd_q  <= fwd_q;
      o_lat_q  <= lat_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign pos_x_o            = o_posx_q;
  assign pos_y_o            = o_posy_q;
  assign world_vel_x_o      = o_vwx_q;
  assign world_vel_y_o      = o_vwy_q;
  assign heading_o          = o_head_q;
  assign yaw_rate_o         = o_rate_q;
  assign body_vel_forward_o = o_fwd_q;
  assign body_vel_lateral_o = o_lat_q;

endmodule

// File: rtl/core/vds_checker.sv
// port-level checks for the vehicle dynamics step, bound to the top level
module vds_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [18:0] heading_o
);

  // a step occupies the sequencer, so no second transaction right behind it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a step is in progress");

  // a fresh result only appears at the end of a step
  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a step finishing");

  // wrapped heading stays within plus or minus pi
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_o >= -19'sd205887) && (heading_o <= 19'sd205886))
    else $error("heading outside the wrapped range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

endmodule

bind vehicle_dynamics_step vds_checker u_vds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .heading_o   (heading_o)
);

// File: tb/sv/vehicle_dynamics_step_tb.sv
// self-checking testbench for the vehicle dynamics step block
module vehicle_dynamics_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vds_pkg::*;

  localparam int WB_Q8 = 512;
  localparam int FARM_Q8 = 256;
  localparam int RARM_Q8 = 256;
  localparam int NSTEPS = 16;
  localparam int N_RANDOM = 1300;
  // settle wait: the slowest step, with idle margin on each side
  localparam int SETTLE_CYC = 4 * NSTEPS + 70;

  typedef struct packed {
    logic signed [16:0] steer;
    logic [6:0]         thr;
    logic [6:0]         brk;
    logic [15:0]        dt;
    logic               half_f;
    logic               half_r;
  } step_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [18:0] hd;
    logic signed [31:0] yr;
    logic signed [31:0] bf;
    logic signed [31:0] bl;
  } result_t;

  // directed row: a step, optionally with a typed-in expected result
  typedef struct {
    step_t   stim;
    bit      has_exp;
    result_t exp_res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [16:0] steer_angle_i;
  logic [6:0] throttle_level_i;
  logic [6:0] brake_level_i;
  logic [15:0] time_step_i;
  logic front_half_grip_i;
  logic rear_half_grip_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [31:0] pos_x_o, pos_y_o, world_vel_x_o, world_vel_y_o;
  logic signed [18:0] heading_o;
  logic signed [31:0] yaw_rate_o, body_vel_forward_o, body_vel_lateral_o;

  vehicle_dynamics_step #(
    .WHEELBASE_Q8(WB_Q8), .FRONT_ARM_Q8(FARM_Q8), .REAR_ARM_Q8(RARM_Q8),
    .CORDIC_STEPS(NSTEPS)
  ) u_top (.*);

  // predictor copies of configuration and car state
  longint stiff_f, stiff_r, grip_lim, load_half, inv_mass, inv_iner, roll_k, drag_k;
  longint car_px, car_py, car_vx, car_vy, car_hd, car_yr;

  result_t expected_q[$];
  int  errors;
  bit  stim_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(64'd12 * 64'd1000 * (N_RANDOM + 200) * 64'd1000 / 1000);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint shr(longint x, int n);
    return x >>> n;  // arithmetic, toward minus infinity
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return clip32(shr(a * b, 16));
  endfunction

  function automatic longint fold_angle(longint a);
    longint r;
    r = (a + PI_Q) % TWO_PI_Q;
    if (r < 0) r += TWO_PI_Q;
    return r - PI_Q;
  endfunction

  function automatic longint atan_step(int i);
    return (i <= 16) ? longint'(atan_lut(i[4:0])) : 0;
  endfunction

  // rotation-mode cordic giving sine and cosine
  function automatic void rotate_unit(input longint a, output longint s, output longint c);
    longint x, y, z, nx;
    bit neg;
    x = CORDIC_GAIN; y = 0; neg = 0;
    z = fold_angle(a);
    if (z > HALF_PI_Q) begin
      z -= PI_Q; neg = 1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q; neg = 1;
    end
    for (int i = 0; i < NSTEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= atan_step(i);
      end else begin
        nx = x + shr(y, i); y = y - shr(x, i); z += atan_step(i);
      end
      x = nx;
    end
    s = neg ? -y : y;
    c = neg ? -x : x;
  endfunction

  // vectoring-mode cordic giving atan(num/den)
  function automatic longint angle_of(longint num, longint den);
    longint x, y, z, nx;
    x = den < 0 ? -den : den;
    y = den < 0 ? -num : num;
    z = 0;
    for (int i = 0; i < NSTEPS && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + shr(y, i); y = y - shr(x, i); z += atan_step(i);
      end else begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= atan_step(i);
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic longint grip_clamp(longint v);
    if (v > grip_lim) return grip_lim;
    if (v < -grip_lim) return -grip_lim;
    return v;
  endfunction

  // rolling resistance plus quadratic drag, opposing motion
  function automatic longint drag_force(longint v);
    longint mag;
    mag = v < 0 ? -v : v;
    return clip32(-(fxmul(roll_k, v) + fxmul(fxmul(drag_k, v), mag)));
  endfunction

  task automatic reset_car();
    stiff_f = -327680; stiff_r = -340787; grip_lim = 131072; load_half = 481689600;
    inv_mass = 2863311; inv_iner = 2863311; roll_k = 1966080; drag_k = 327680;
    car_px = -2621440; car_py = 1310720;
    car_vx = 0; car_vy = 0; car_hd = 0; car_yr = 0;
  endtask

  task automatic set_register(input logic [3:0] idx, input logic [31:0] val);
    case (idx)
      CFG_CORNER_F:  stiff_f = longint'($signed(val));
      CFG_CORNER_R:  stiff_r = longint'($signed(val));
      CFG_MAX_GRIP:  grip_lim = longint'(val[30:0]);
      CFG_AXLE_LOAD: load_half = longint'(val[30:0]);
      CFG_INV_MASS:  inv_mass = longint'(val);
      CFG_INV_INER:  inv_iner = longint'(val);
      CFG_ROLLING:   roll_k = longint'(val[30:0]);
      CFG_DRAG:      drag_k = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  // one euler step of the car body, returns the result it emits
  function automatic result_t advance_car(step_t s);
    longint steer, thr, brk, dt, sh, ch, ss, cs, fwd, lat, yawv;
    longint yaw_ang, beta, slip_f, slip_r, lat_f, lat_r, dir, trac;
    longint f_fwd, f_lat, moment, a_fwd, a_lat, a_ang, awx, awy;
    result_t r;
    steer = longint'(s.steer); thr = s.thr; brk = s.brk; dt = s.dt;
    rotate_unit(car_hd, sh, ch);
    fwd = clip32(fxmul(ch, car_vy) + fxmul(sh, car_vx));
    lat = clip32(fxmul(ch, car_vx) - fxmul(sh, car_vy));
    yawv = shr(longint'(WB_Q8) * car_yr, 9);
    yaw_ang = 0; beta = 0;
    if (fwd != 0) begin
      yaw_ang = angle_of(yawv, fwd);
      beta = angle_of(lat, fwd);
    end
    slip_f = beta + yaw_ang - steer;
    slip_r = beta - yaw_ang;
    lat_f = fxmul(grip_clamp(fxmul(stiff_f, slip_f)), load_half);
    if (s.half_f) lat_f = shr(lat_f, 1);
    lat_r = fxmul(grip_clamp(fxmul(stiff_r, slip_r)), load_half);
    if (s.half_r) lat_r = shr(lat_r, 1);
    dir = fwd > 0 ? 1 : (fwd < 0 ? -1 : 0);
    trac = 64'sd6553600 * (thr - brk * dir);
    if (s.half_r) trac = shr(trac, 1);
    rotate_unit(steer, ss, cs);
    f_fwd = clip32(trac + drag_force(fwd));
    f_lat = clip32(fxmul(cs, lat_f) + lat_r + drag_force(lat));
    moment = clip32(shr(longint'(FARM_Q8) * lat_f - longint'(RARM_Q8) * lat_r, 8));
    a_fwd = clip32(shr(f_fwd * inv_mass, 32));
    a_lat = clip32(shr(f_lat * inv_mass, 32));
    a_ang = clip32(shr(moment * inv_iner, 32));
    awx = clip32(fxmul(ch, a_lat) + fxmul(sh, a_fwd));
    awy = clip32(fxmul(ch, a_fwd) - fxmul(sh, a_lat));
    car_vx = clip32(car_vx + shr(dt * awx, 16));
    car_vy = clip32(car_vy + shr(dt * awy, 16));
    car_px = clip32(car_px + shr(dt * car_vx, 16));
    car_py = clip32(car_py + shr(dt * car_vy, 16));
    car_yr = clip32(car_yr + shr(dt * a_ang, 16));
    car_hd = fold_angle(car_hd + shr(dt * car_yr, 16));
    r.px = car_px[31:0]; r.py = car_py[31:0];
    r.vx = car_vx[31:0]; r.vy = car_vy[31:0];
    r.hd = car_hd[18:0]; r.yr = car_yr[31:0];
    r.bf = fwd[31:0]; r.bl = lat[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drive side
  // ---------------------------------------------------------------------------

  task automatic push_step(input step_t s);
    int idle;
    in_valid_i        <= 1'b1;
    steer_angle_i     <= s.steer;
    throttle_level_i  <= s.thr;
    brake_level_i     <= s.brk;
    time_step_i       <= s.dt;
    front_half_grip_i <= s.half_f;
    rear_half_grip_i  <= s.half_r;
    do @(posedge clk_i); while (!in_ready_o);
    // transaction accepted at this edge: queue what it must produce
    expected_q.push_back(advance_car(s));
    // gap before the next transaction
    idle = $urandom_range(0, 12) * ($urandom_range(0, 3) != 0);
    if (idle != 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // drain, then give the sequencer time to settle before a register write
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    set_register(idx, val);
  endtask

  function automatic step_t rand_step(bit steady);
    step_t s;
    s.steer  = steady ? 17'($signed($urandom_range(0, 102944)) - 51472)
                      : 17'($urandom());
    s.thr    = steady ? 7'($urandom_range(0, 100)) : 7'($urandom());
    s.brk    = steady ? 7'($urandom_range(0, 30) * ($urandom_range(0, 3) == 0))
                      : 7'($urandom());
    // mostly short steps, sometimes long or zero
    case ($urandom_range(0, 9))
      0:       s.dt = 16'd0;
      1:       s.dt = 16'($urandom());
      default: s.dt = 16'($urandom_range(0, 4000));
    endcase
    s.half_f = 1'($urandom());
    s.half_r = 1'($urandom());
    return s;
  endfunction

  // random register setting, extremes included
  task automatic random_setting();
    logic [31:0] v;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 4))
        0:       v = 32'h0;
        1:       v = 32'hffff_ffff;
        2:       v = 32'h7fff_ffff;
        default: v = $urandom();
      endcase
      write_reg(i[3:0], v);
    end
    write_reg(4'd9, $urandom());  // unknown index, dropped
    cfg_valid_i <= 1'b0;
  endtask

  // directed table: extremes, special cases, reset-state check
  row_t dir_rows[$];

  task automatic build_table();
    row_t r;
    result_t z;
    z = '0;
    // zero step straight after reset leaves the car parked at (-40, 20)
    r.stim = '{17'sd0, 7'd0, 7'd0, 16'd0, 1'b0, 1'b0};
    r.has_exp = 1;
    z.px = POS_X_RST; z.py = POS_Y_RST;
    r.exp_res = z;
    dir_rows.push_back(r);
    r.has_exp = 0;
    r.stim = '{17'sd51472, 7'd100, 7'd0, 16'd655, 1'b0, 1'b0};   dir_rows.push_back(r);
    r.stim = '{-17'sd51472, 7'd100, 7'd0, 16'd655, 1'b1, 1'b0};  dir_rows.push_back(r);
    r.stim = '{17'sd0, 7'd127, 7'd0, 16'd65535, 1'b0, 1'b1};     dir_rows.push_back(r);
    r.stim = '{17'sd65535, 7'd0, 7'd127, 16'd1000, 1'b1, 1'b1};  dir_rows.push_back(r);
    r.stim = '{-17'sd65536, 7'd50, 7'd100, 16'd1000, 1'b0, 1'b0}; dir_rows.push_back(r);
    r.stim = '{17'sd1234, 7'd0, 7'd0, 16'd0, 1'b1, 1'b1};        dir_rows.push_back(r);
    r.stim = '{17'sd20000, 7'd127, 7'd127, 16'd65535, 1'b0, 1'b0}; dir_rows.push_back(r);
    for (int i = 0; i < 8; i++) begin
      r.stim = '{17'($signed(i * 9000 - 36000)), 7'd100, 7'd0, 16'd3000, i[0], i[1]};
      dir_rows.push_back(r);
    end
  endtask

  initial begin
    step_t s;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0;
    steer_angle_i = '0; throttle_level_i = '0; brake_level_i = '0; time_step_i = '0;
    front_half_grip_i = 1'b0; rear_half_grip_i = 1'b0;
    errors = 0; stim_done = 0;
    reset_car();
    build_table();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      push_step(dir_rows[i].stim);
      if (dir_rows[i].has_exp && expected_q[$] != dir_rows[i].exp_res) begin
        $error("typed row %0d: predictor exp %h act %h", i, dir_rows[i].exp_res,
               expected_q[$]);
        errors++;
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      if (ph == 5) begin
        // back to the defaults for a long natural drive
        write_reg(CFG_CORNER_F, -32'sd327680);  write_reg(CFG_CORNER_R, -32'sd340787);
        write_reg(CFG_MAX_GRIP, 32'd131072);    write_reg(CFG_AXLE_LOAD, 32'd481689600);
        write_reg(CFG_INV_MASS, 32'd2863311);   write_reg(CFG_INV_INER, 32'd2863311);
        write_reg(CFG_ROLLING, 32'd1966080);    write_reg(CFG_DRAG, 32'd327680);
        cfg_valid_i <= 1'b0;
      end else begin
        random_setting();
      end
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        s = rand_step($urandom_range(0, 4) != 0);
        push_step(s);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // ---------------------------------------------------------------------------
  // receive side: random backpressure and field checks
  // ---------------------------------------------------------------------------

  initial begin
    int stall;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        // transaction taken at this edge
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
      end else if (!out_ready_i) begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d actual %0d", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result with no expected step pending");
        errors++;
      end else begin
        e = expected_q.pop_front();
        cmp("pos_x", e.px, pos_x_o);
        cmp("pos_y", e.py, pos_y_o);
        cmp("world_vel_x", e.vx, world_vel_x_o);
        cmp("world_vel_y", e.vy, world_vel_y_o);
        cmp("heading", e.hd, heading_o);
        cmp("yaw_rate", e.yr, yaw_rate_o);
        cmp("body_vel_forward", e.bf, body_vel_forward_o);
        cmp("body_vel_lateral", e.bl, body_vel_lateral_o);
      end
    end
  end

  // end of run: drain, then watch for stray results
  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
